>>> rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared constants and types for the RPN stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;
   localparam int StackDepth = 128;
   localparam int PtrW       = $clog2(StackDepth);
   localparam int CntW       = $clog2(StackDepth + 1);

   localparam logic [2:0] MODE_PUSH = 3'd0;
   localparam logic [2:0] MODE_ADD  = 3'd1;
   localparam logic [2:0] MODE_SUB  = 3'd2;
   localparam logic [2:0] MODE_MUL  = 3'd3;
   localparam logic [2:0] MODE_DIV  = 3'd4;
   localparam logic [2:0] MODE_MOD  = 3'd5;
   localparam logic [2:0] MODE_POP  = 3'd6;
   localparam logic [2:0] MODE_NONE = 3'd7;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_FULL  = 3'd2;
   localparam logic [2:0] ST_DIVZ  = 3'd3;
   localparam logic [2:0] ST_SAT   = 3'd4;

   typedef logic [CntW-1:0] cnt_type;
   typedef logic [PtrW-1:0] ptr_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;
endpackage

>>> rtl/rpn_divider.sv
// ----------------------------------------------------------------------------
// RPN divider
// Restoring signed divider, one quotient bit per cycle, 48 quotient bits.
// ----------------------------------------------------------------------------
module rpn_divider (
   input  logic                clock,
   input  logic                reset,
   input  rpn_pkg::div_req_type req,
   output logic                done,
   output logic [63:0]         quotient,
   output logic [31:0]         remainder
);
   import rpn_pkg::*;

   localparam int Steps = 48;

   logic [5:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic [47:0] num_ff, num_in;
   logic [31:0] den_ff, den_in;
   logic [32:0] rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [63:0] dvd_abs;

   always_comb begin
      step_in = step_ff; busy_in = busy_ff; qneg_in = qneg_ff; rneg_in = rneg_ff;
      num_in = num_ff; den_in = den_ff; rem_in = rem_ff; quo_in = quo_ff;
      done_in = 1'b0;
      dvd_abs = req.dividend[63] ? (~req.dividend + 64'd1) : req.dividend;
      trial = {rem_ff[31:0], num_ff[47]} - {1'b0, den_ff};
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         // magnitude of a*65536 fits 48 bits
         num_in  = dvd_abs[47:0];
         den_in  = req.divisor[31] ? (~req.divisor + 32'd1) : req.divisor;
         qneg_in = req.dividend[63] ^ req.divisor[31];
         rneg_in = req.dividend[63];
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[46:0], 1'b0};
         if (!trial[32]) begin
            rem_in = trial;
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], num_ff[47]};
            quo_in = {quo_ff[46:0], 1'b0};
         end
         step_in = step_ff + 6'd1;
         if (step_ff == 6'(Steps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      qneg_ff <= qneg_in; rneg_ff <= rneg_in;
      num_ff <= num_in; den_ff <= den_in; rem_ff <= rem_in; quo_ff <= quo_in;
   end

   assign done      = done_ff;
   assign quotient  = qneg_ff ? (~{16'd0, quo_ff} + 64'd1) : {16'd0, quo_ff};
   assign remainder = rneg_ff ? (~rem_ff[31:0] + 32'd1) : rem_ff[31:0];
endmodule

>>> rtl/rpn_stack_calculator_unit.sv
// ----------------------------------------------------------------------------
// RPN stack calculator unit
// Reverse Polish evaluator on a Q16.16 operand stack held in one memory.
// ----------------------------------------------------------------------------
// Sequence, accept to strobe: push and unused selector go to write-back; pop
// and divide/modulo by zero read b only; add/sub/multiply read b and a, then
// register the product; divide/modulo read b and a, then wait on the 48-step
// divider. Busy drops as the strobe rises. One item at a time, taken in idle.
// Reset clears the stack count and the sequencer; memory contents are
// undefined, never read before written. The receiver cannot stall results.
module rpn_stack_calculator_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_mode,
   input  logic signed [31:0]  req_operand_value,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_result_value,
   output logic [2:0]          rsp_status
);
   import rpn_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RDB  = 3'd1;  // read data of b arrives
   localparam logic [2:0] S_RDA  = 3'd2;  // read data of a arrives
   localparam logic [2:0] S_MUL  = 3'd3;  // product registered
   localparam logic [2:0] S_DIV  = 3'd4;  // wait for divider
   localparam logic [2:0] S_WB   = 3'd5;  // raise the result strobe

   logic [31:0] mem [StackDepth];
   logic [31:0] rdata_ff;
   logic        re;
   ptr_type     raddr;
   logic        we;
   ptr_type     waddr;
   logic [31:0] wdata;

   logic [2:0]  state_ff, state_in;
   cnt_type     cnt_ff, cnt_in;
   logic [2:0]  mode_ff, mode_in;
   logic [31:0] opnd_ff, opnd_in;
   logic [31:0] b_ff, b_in, a_ff, a_in;
   logic        emp_ff, emp_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] res_ff, res_in;
   logic [2:0]  stat_ff, stat_in;
   logic        vld_ff, vld_in;
   div_req_type dreq;
   logic        ddone;
   logic [63:0] dquo;
   logic [31:0] drem;
   logic [32:0] sum;
   logic [63:0] mshift, wide;
   logic        sat;
   logic [31:0] satv;

   rpn_divider u_div (
      .clock, .reset, .req(dreq), .done(ddone), .quotient(dquo), .remainder(drem)
   );

   // single-port style memory: registered read, one write
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   always_comb begin
      // arithmetic shift right of the product is floor division by 65536
      mshift = {{16{prod_ff[63]}}, prod_ff[63:16]};
      if (mode_ff == MODE_ADD)
         sum = {a_ff[31], a_ff} + {b_ff[31], b_ff};
      else
         sum = {a_ff[31], a_ff} - {b_ff[31], b_ff};
      if (mode_ff == MODE_MUL)      wide = mshift;
      else if (mode_ff == MODE_DIV) wide = dquo;
      else                          wide = {{31{sum[32]}}, sum};
      sat  = (wide[63:31] != {33{wide[31]}}) && (mode_ff != MODE_MOD);
      satv = sat ? (wide[63] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                 : (mode_ff == MODE_MOD ? drem : wide[31:0]);
   end

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; mode_in = mode_ff; opnd_in = opnd_ff;
      b_in = b_ff; a_in = a_ff; emp_in = emp_ff; prod_in = prod_ff;
      res_in = res_ff; stat_in = stat_ff; vld_in = 1'b0;
      re = 1'b0; raddr = '0; we = 1'b0; waddr = '0; wdata = '0;
      dreq = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = req_mode; opnd_in = req_operand_value;
               emp_in = 1'b0;
               priority if (req_mode == MODE_PUSH) begin
                  // push: write now, report from S_WB
                  res_in = '0;
                  if (cnt_ff < cnt_type'(StackDepth)) begin
                     we = 1'b1; waddr = ptr_type'(cnt_ff); wdata = req_operand_value;
                     cnt_in = cnt_ff + 1'b1; stat_in = ST_OK;
                  end else stat_in = ST_FULL;
                  state_in = S_WB;
               end else if (req_mode == MODE_NONE) begin
                  res_in = '0; stat_in = ST_OK; state_in = S_WB;
               end else begin
                  // pop b
                  if (cnt_ff != '0) begin
                     re = 1'b1; raddr = ptr_type'(cnt_ff - 1'b1);
                     cnt_in = cnt_ff - 1'b1; b_in = '1; // marker: valid read
                  end else begin
                     emp_in = 1'b1; b_in = '0;
                  end
                  state_in = S_RDB;
               end
            end
         end
         S_RDB: begin
            if (!emp_ff) b_in = rdata_ff;
            if (mode_ff == MODE_POP) begin
               res_in = emp_ff ? '0 : rdata_ff;
               stat_in = emp_ff ? ST_EMPTY : ST_OK;
               state_in = S_WB;
            end else if ((mode_ff == MODE_DIV || mode_ff == MODE_MOD) &&
                         (emp_ff || rdata_ff == '0)) begin
               res_in = '0; stat_in = ST_DIVZ; state_in = S_WB;
            end else begin
               if (cnt_ff != '0) begin
                  re = 1'b1; raddr = ptr_type'(cnt_ff - 1'b1);
                  cnt_in = cnt_ff - 1'b1; a_in = '1;
               end else begin
                  emp_in = 1'b1; a_in = '0;
               end
               // remember whether a read happened in opnd (unused after push)
               opnd_in = {31'd0, cnt_ff != '0};
               state_in = S_RDA;
            end
         end
         S_RDA: begin
            if (opnd_ff[0]) a_in = rdata_ff;
            else a_in = '0;
            prod_in = 64'($signed(opnd_ff[0] ? rdata_ff : 32'd0)) * 64'($signed(b_ff));
            if (mode_ff == MODE_DIV || mode_ff == MODE_MOD) begin
               dreq.start    = 1'b1;
               dreq.dividend = {{16{a_in[31]}}, a_in, 16'd0};
               if (mode_ff == MODE_MOD) dreq.dividend = {{32{a_in[31]}}, a_in};
               dreq.divisor  = b_ff;
               state_in = S_DIV;
            end else state_in = S_MUL;
         end
         S_MUL, S_DIV: begin
            if (state_ff == S_MUL || ddone) begin
               res_in = satv;
               if (cnt_ff < cnt_type'(StackDepth)) begin
                  we = 1'b1; waddr = ptr_type'(cnt_ff); wdata = satv;
                  cnt_in = cnt_ff + 1'b1;
               end
               priority if (emp_ff) stat_in = ST_EMPTY;
               else if (cnt_ff >= cnt_type'(StackDepth)) stat_in = ST_FULL;
               else if (sat) stat_in = ST_SAT;
               else stat_in = ST_OK;
               state_in = S_WB;
            end
         end
         S_WB: begin
            vld_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
      mode_ff <= mode_in; opnd_ff <= opnd_in; b_ff <= b_in; a_ff <= a_in;
      emp_ff <= emp_in; prod_ff <= prod_in; res_ff <= res_in; stat_ff <= stat_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = vld_ff;
   assign rsp_result_value = res_ff;
   assign rsp_status       = stat_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= cnt_type'(StackDepth)) else $error("stack count out of range");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("strobe while busy");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double strobe");
   a_wb_strobe: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WB |=> rsp_valid) else $error("missing strobe");
endmodule

>>> test/rpn_stack_calculator_unit_test.sv
// ----------------------------------------------------------------------------
// RPN stack calculator unit testbench
// Drives push, arithmetic, pop and no-op beats via the start/busy command port,
// predicts each result on a private copy of the operand stack, and compares
// every strobed result in order against the oldest predicted one.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rpn_pkg::*;

   localparam int WatchdogLimit = 20000;

   typedef struct {
      logic signed [31:0] value;
      logic [2:0]         status;
   } calc_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_mode = MODE_PUSH;
   logic signed [31:0] req_operand_value = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_result_value;
   logic [2:0]         rsp_status;

   // Model of the operand stack.
   logic signed [31:0] model_stack [StackDepth];
   int                 model_depth = 0;

   calc_result_type    pending_results [$];
   int                 error_count = 0;
   int                 idle_percent = 30;
   int                 quiet_cycles = 0;

   always #5 clock = ~clock;

   rpn_stack_calculator_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status)
   );

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic calc_result_type evaluate_rpn(input logic [2:0] mode,
                                                   input logic signed [31:0] operand);
      calc_result_type r;
      logic signed [63:0]  a, b, v;
      logic signed [127:0] wide;
      bit  f_empty, f_full, f_divz, f_sat, do_store;
      a = 0; b = 0; v = 0; wide = 0;
      f_empty = 0; f_full = 0; f_divz = 0; f_sat = 0; do_store = 0;
      r.value = '0;

      // Pop right operand first, then left, for every binary operation.
      if (mode inside {MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD, MODE_POP}) begin
         if (model_depth > 0) begin
            model_depth--;
            b = model_stack[model_depth];
         end else begin
            f_empty = 1;
         end
      end
      if (mode inside {MODE_DIV, MODE_MOD} && b == 0) begin
         // Divisor dropped, dividend left in place, nothing pushed.
         f_divz = 1;
      end else if (mode inside {MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD}) begin
         if (model_depth > 0) begin
            model_depth--;
            a = model_stack[model_depth];
         end else begin
            f_empty = 1;
         end
         case (mode)
            MODE_ADD: v = a + b;
            MODE_SUB: v = a - b;
            MODE_MUL: v = (a * b) >>> 16;   // arithmetic shift floors
            MODE_DIV: begin
               wide = (128'(signed'(a)) <<< 16) / 128'(signed'(b));
               v = (wide > 128'sd2147483647) ? 64'sd2147483648 :
                   (wide < -128'sd2147483648) ? -64'sd2147483649 : 64'(wide);
            end
            default:  v = a % b;            // sign follows dividend
         endcase
         if (v > 64'sd2147483647) begin
            v = 64'sd2147483647; f_sat = 1;
         end else if (v < -64'sd2147483648) begin
            v = -64'sd2147483648; f_sat = 1;
         end
         do_store = 1;
      end else if (mode == MODE_POP) begin
         v = b;
      end else if (mode == MODE_PUSH) begin
         v = operand;
         do_store = 1;
      end

      if (do_store) begin
         if (model_depth < StackDepth) begin
            model_stack[model_depth] = v[31:0];
            model_depth++;
         end else begin
            f_full = 1;
         end
      end
      if (mode == MODE_PUSH) v = 0;

      r.value  = v[31:0];
      r.status = f_divz ? ST_DIVZ : f_empty ? ST_EMPTY : f_full ? ST_FULL :
                 f_sat ? ST_SAT : ST_OK;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Send one beat: optional idle gap, then hold start until accepted.
   // ------------------------------------------------------------------------
   task automatic send_beat(input logic [2:0] mode, input logic signed [31:0] operand);
      while ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_mode          <= mode;
      req_operand_value <= operand;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
      pending_results.push_back(evaluate_rpn(mode, operand));
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Result checker and watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      calc_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result beat value=%0d status=%0d",
                   rsp_result_value, rsp_status);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_result_value !== exp_r.value) begin
               $error("result_value expected %0d actual %0d", exp_r.value, rsp_result_value);
               error_count++;
            end
            if (rsp_status !== exp_r.status) begin
               $error("status expected %0d actual %0d", exp_r.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("rpn_stack_calculator_unit: mismatch");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic signed [31:0] random_operand();
      case ($urandom_range(5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 0;
         3: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_beat(MODE_POP, 0);                     // pop on an empty stack
      send_beat(MODE_ADD, 0);                     // arithmetic on an empty stack
      send_beat(MODE_PUSH, 32'sh7FFF_FFFF);
      send_beat(MODE_PUSH, 32'sh7FFF_FFFF);
      send_beat(MODE_ADD, 0);                     // positive saturation
      send_beat(MODE_PUSH, 32'sh8000_0000);
      send_beat(MODE_SUB, 0);                     // difference saturates
      send_beat(MODE_PUSH, 32'sh8000_0000);
      send_beat(MODE_MUL, 0);                     // product saturates
      send_beat(MODE_PUSH, -32'sh0001_8000);
      send_beat(MODE_MUL, 0);                     // positive product saturates
      send_beat(MODE_PUSH, 32'sh0003_0000);
      send_beat(MODE_PUSH, 0);
      send_beat(MODE_DIV, 0);                     // divide by zero keeps dividend
      send_beat(MODE_PUSH, -32'sh0002_0000);
      send_beat(MODE_MOD, 0);
      send_beat(MODE_PUSH, 0);
      send_beat(MODE_MOD, 0);                     // modulo by zero
      send_beat(MODE_PUSH, 32'sh0000_0001);
      send_beat(MODE_DIV, 0);                     // quotient saturates
      send_beat(MODE_PUSH, -32'sh0000_0007);
      send_beat(MODE_DIV, 0);
      send_beat(MODE_NONE, 32'sh1234_5678);       // unused selector is a no-op
      send_beat(MODE_POP, 0);
      send_beat(MODE_POP, 0);
   endtask

   task automatic test_full_stack();
      // Fill the stack to the top, check the full flag on pushes past it, add, drain.
      while (model_depth < StackDepth + 2) begin
         send_beat(MODE_PUSH, random_operand());
         if (model_depth == StackDepth) send_beat(MODE_PUSH, random_operand());
         if (model_depth == StackDepth) break;
      end
      send_beat(MODE_PUSH, 32'sh0001_0000);
      send_beat(MODE_ADD, 0);
      while (model_depth > 0) send_beat(MODE_POP, 0);
   endtask

   task automatic test_random(input int count);
      logic [2:0] mode;
      repeat (count) begin
         // Keep the stack shallow mostly, with occasional noise ops.
         if (model_depth < 2 && $urandom_range(99) < 70) mode = MODE_PUSH;
         else if ($urandom_range(99) < 3) mode = MODE_NONE;
         else mode = 3'($urandom_range(MODE_POP));
         send_beat(mode, random_operand());
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_percent = 30;
      test_directed();
      test_full_stack();
      test_random(110);
      idle_percent = 78;
      test_random(110);
      idle_percent = 0;
      test_random(110);
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("rpn_stack_calculator_unit: match");
      end else begin
         $display("rpn_stack_calculator_unit: mismatch");
      end
      $finish;
   end
endmodule
